>>> design/srrw_pkg.sv
// Shared types and constants for the selective-repeat receive window.
`timescale 1ns / 1ps
`default_nettype none
package srrw_pkg;

  // Sequence space and window size
  localparam int SEQ_SPACE = 16;
  localparam int WINDOW    = 8;

  localparam int SEQ_W  = $clog2(SEQ_SPACE);
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int ALU_W  = (SEQ_W > CNT_W) ? SEQ_W : CNT_W;

  localparam logic [CNT_W-1:0] WINDOW_CNT = CNT_W'(WINDOW);

  // Request opcodes
  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_CONSUME = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_NEW      = 3'd0,
    ST_DUP      = 3'd1,
    ST_OUT_WIN  = 3'd2,
    ST_CONSUMED = 3'd3,
    ST_NOTHING  = 3'd4
  } status_t;

  typedef struct packed {
    logic             opcode;
    logic [SEQ_W-1:0] seq_number;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] buffer_slot;
    logic [CNT_W-1:0]  delivered_now;
    logic [SEQ_W-1:0]  ack_seq;
    logic [CNT_W-1:0]  ack_window;
    logic              no_space;
    logic [CNT_W-1:0]  waiting_messages;
  } out_item_t;

  // Shared add/subtract unit request and response
  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             lt;
  } alu_rsp_t;

endpackage
`default_nettype wire

>>> design/srrw_addsub.sv
// Shared add/subtract unit with unsigned less-than flag.
`timescale 1ns / 1ps
`default_nettype none
module srrw_addsub
  import srrw_pkg::*;
(
  input  var alu_req_t req,
  output var alu_rsp_t rsp
);

  logic [ALU_W:0]   full_sum;
  logic [ALU_W-1:0] b_eff;

  // Subtract as add of the inverted operand plus one
  assign b_eff    = req.sub ? ~req.b : req.b;
  assign full_sum = {1'b0, req.a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, req.sub};

  // Borrow out of a subtract means a < b
  assign rsp.sum = full_sum[ALU_W-1:0];
  assign rsp.lt  = req.sub & ~full_sum[ALU_W];

endmodule
`default_nettype wire

>>> design/selective_repeat_receive_window.sv
// Top level of the selective-repeat receive window sequencer.
// Receive side of a selective-repeat window for one connection.
// Input channel (in_valid/in_ready/in_data) carries one request: a data
// packet with its sequence number, or a consume of one delivered message.
// Result channel (out_valid/out_ready/out_data) returns exactly one result
// per request: status, payload buffer slot, messages delivered by the slide,
// cumulative ACK sequence, advertised window, no-space flag, waiting count.
// Steps after accept, with d slide steps made (d from 0 to 8):
//   in-window data packet: offset, check, slot, then d slide steps
//   out-of-window packet:  offset and check
//   consume:               a single consume step
// One add/subtract unit does every offset, compare, slot and base step, and
// the slide walks one marked entry per cycle through it; in_ready is high
// only while the sequencer is idle, so a new request is not taken until the
// last one has left the sequencer.
// A finished result sits in the output register; the sequencer may accept
// and work on the next request while it waits, and holds its own result
// until the output register frees up when the receiver stalls.
// Synchronous reset (rst_n low) empties the window: base 0, free space
// equal to the window, all marks clear, nothing waiting, no result pending.
`timescale 1ns / 1ps
`default_nettype none
module selective_repeat_receive_window
  import srrw_pkg::*;
(
  input  var logic      clk,
  input  var logic      rst_n,
  input  var logic      in_valid,
  output var logic      in_ready,
  input  var in_item_t  in_data,
  output var logic      out_valid,
  input  var logic      out_ready,
  output var out_item_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_OFFSET,
    S_CHECK,
    S_SLOT,
    S_SLIDE,
    S_CONSUME,
    S_DONE
  } state_t;

  state_t             state_r;
  logic [SEQ_W-1:0]   base_r;
  logic [CNT_W-1:0]   free_r;
  logic [SEQ_SPACE-1:0] marks_r;
  logic [SLOT_W-1:0]  write_slot_r;
  logic [CNT_W-1:0]   waiting_r;
  logic               full_r;

  logic [SEQ_W-1:0]   seq_r;
  logic [SEQ_W-1:0]   offset_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [CNT_W-1:0]   delivered_r;
  status_t            status_r;

  logic               out_valid_r;
  out_item_t          out_data_r;

  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;
  logic [SEQ_W-1:0]   mark_addr;
  logic               mark_bit;
  logic               accept;
  logic               out_free;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // Single mark read port: base during the slide, packet sequence otherwise
  assign mark_addr = (state_r == S_SLIDE) ? base_r : seq_r;
  assign mark_bit  = marks_r[mark_addr];

  // Steer operands into the shared unit
  always_comb begin
    alu_req = '0;
    unique case (state_r)
      S_OFFSET: begin
        alu_req.a   = ALU_W'(seq_r);
        alu_req.b   = ALU_W'(base_r);
        alu_req.sub = 1'b1;
      end
      S_CHECK: begin
        alu_req.a   = ALU_W'(offset_r);
        alu_req.b   = ALU_W'(free_r);
        alu_req.sub = 1'b1;
      end
      S_SLOT: begin
        alu_req.a   = ALU_W'(write_slot_r);
        alu_req.b   = ALU_W'(offset_r);
        alu_req.sub = 1'b0;
      end
      S_SLIDE: begin
        alu_req.a   = ALU_W'(base_r);
        alu_req.b   = ALU_W'(1);
        alu_req.sub = 1'b0;
      end
      S_CONSUME: begin
        alu_req.a   = ALU_W'(waiting_r);
        alu_req.b   = ALU_W'(1);
        alu_req.sub = 1'b1;
      end
      default: alu_req = '0;
    endcase
  end

  srrw_addsub u_addsub (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Sequencer, window state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      base_r       <= '0;
      free_r       <= WINDOW_CNT;
      marks_r      <= '0;
      write_slot_r <= '0;
      waiting_r    <= '0;
      full_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // Raise valid on a finished result, drop it once the receiver takes it
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            seq_r       <= in_data.seq_number;
            slot_r      <= '0;
            delivered_r <= '0;
            state_r     <= (in_data.opcode == OP_CONSUME) ? S_CONSUME : S_OFFSET;
          end
        end

        // Distance of the packet from the base, wrapped
        S_OFFSET: begin
          offset_r <= alu_rsp.sum[SEQ_W-1:0];
          state_r  <= S_CHECK;
        end

        // Inside the window only if offset is below the free space
        S_CHECK: begin
          if (alu_rsp.lt) begin
            state_r <= S_SLOT;
          end else begin
            status_r <= ST_OUT_WIN;
            state_r  <= S_DONE;
          end
        end

        // Name the payload slot and mark the packet
        S_SLOT: begin
          slot_r         <= alu_rsp.sum[SLOT_W-1:0];
          status_r       <= mark_bit ? ST_DUP : ST_NEW;
          marks_r[seq_r] <= 1'b1;
          state_r        <= S_SLIDE;
        end

        // Advance the base over one contiguous marked entry per cycle
        S_SLIDE: begin
          if ((free_r != '0) && mark_bit) begin
            marks_r[base_r] <= 1'b0;
            base_r          <= alu_rsp.sum[SEQ_W-1:0];
            write_slot_r    <= write_slot_r + SLOT_W'(1);
            waiting_r       <= waiting_r + CNT_W'(1);
            free_r          <= free_r - CNT_W'(1);
            delivered_r     <= delivered_r + CNT_W'(1);
          end else begin
            full_r  <= (free_r == '0);
            state_r <= S_DONE;
          end
        end

        // Hand one waiting message to the application
        S_CONSUME: begin
          if (waiting_r == '0) begin
            status_r <= ST_NOTHING;
          end else begin
            waiting_r <= alu_rsp.sum[CNT_W-1:0];
            if (free_r < WINDOW_CNT) begin
              free_r <= free_r + CNT_W'(1);
            end
            status_r <= ST_CONSUMED;
          end
          state_r <= S_DONE;
        end

        // Load the result once the output register is free
        S_DONE: begin
          if (out_free) begin
            out_data_r.status           <= status_r;
            out_data_r.buffer_slot      <= slot_r;
            out_data_r.delivered_now    <= delivered_r;
            out_data_r.ack_seq          <= base_r - SEQ_W'(1);
            out_data_r.ack_window       <= free_r;
            out_data_r.no_space         <= full_r;
            out_data_r.waiting_messages <= waiting_r;
            state_r                     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

>>> design/srrw_checker.sv
// Port-level checks for the selective-repeat receive window, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
module srrw_checker
  import srrw_pkg::*;
(
  input var logic      clk,
  input var logic      rst_n,
  input var logic      in_valid,
  input var logic      in_ready,
  input var logic      out_valid,
  input var logic      out_ready,
  input var out_item_t out_data
);

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Go busy after taking a request
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after accept");

  // Free space and waiting messages always split the window
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((CNT_W + 1)'(out_data.ack_window)
                   + (CNT_W + 1)'(out_data.waiting_messages))
                  == (CNT_W + 1)'(WINDOW))
    else $error("window accounting broken");

  // Consume and out-of-window results carry no slot and no slide
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_CONSUMED || out_data.status == ST_NOTHING
                  || out_data.status == ST_OUT_WIN)
    |-> out_data.buffer_slot == '0 && out_data.delivered_now == '0)
    else $error("slot or delivery on non-accepting result");

  // No slide can exceed the window
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.delivered_now <= WINDOW_CNT)
    else $error("slide longer than window");

endmodule

bind selective_repeat_receive_window srrw_checker u_srrw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
